/* design/sohl_pkg.sv */
// Shared types and codes for the split ordered handle list.
package sohl_pkg;

    // Operation codes carried in the low bits of s_tdata
    typedef enum logic [2:0] {
        A_PUSH_NORMAL  = 3'd0,
        A_PUSH_OVERLAY = 3'd1,
        A_POP_NORMAL   = 3'd2,
        A_POP_OVERLAY  = 3'd3,
        A_REM_NORMAL   = 3'd4,
        A_REM_OVERLAY  = 3'd5,
        A_GET          = 3'd6,
        A_CLEAR        = 3'd7
    } action_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NULL      = 3'd4,
        ST_RANGE     = 3'd5
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        M_HOLD,
        M_INSERT,
        M_DELETE,
        M_SEARCH,
        M_SHIFT_HIT,
        M_CLEAR
    } mode_t;

    // Sequencer states
    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } fsm_t;

endpackage

/* design/sohl_cell.sv */
// One list cell: holds one entry and moves it to or from its neighbors.
module sohl_cell import sohl_pkg::*; #(
    parameter int IDX         = 0,
    parameter int HANDLE_BITS = 16,
    parameter int CB          = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mode_t                  mode_i,
    input  logic [CB-1:0]          pos_i,     // insert or delete index
    input  logic [CB-1:0]          lo_i,      // search region, inclusive
    input  logic [CB-1:0]          hi_i,      // search region, exclusive
    input  logic [HANDLE_BITS-1:0] handle_i,
    input  logic [HANDLE_BITS-1:0] left_i,    // entry of the cell below
    input  logic [HANDLE_BITS-1:0] right_i,   // entry of the cell above
    input  logic                   seen_i,    // a hit lies at or below a lower cell
    output logic                   seen_o,
    output logic [HANDLE_BITS-1:0] entry_o
);

    localparam logic [CB-1:0] IDX_C = CB'(IDX);

    logic [HANDLE_BITS-1:0] entry_reg, entry_next;
    logic                   match_reg, match_next;

    // hit flag ripples upward so every cell at or past the first hit shifts
    assign seen_o  = seen_i | match_reg;
    assign entry_o = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        match_next = match_reg;
        unique case (mode_i)
            M_HOLD: begin
            end
            M_INSERT: begin
                if (IDX_C == pos_i) begin
                    entry_next = handle_i;
                end else if (IDX_C > pos_i) begin
                    entry_next = left_i;
                end
            end
            M_DELETE: begin
                if (IDX_C >= pos_i) begin
                    entry_next = right_i;
                end
            end
            M_SEARCH: begin
                match_next = (entry_reg == handle_i) && (IDX_C >= lo_i) && (IDX_C < hi_i);
            end
            M_SHIFT_HIT: begin
                if (seen_o) begin
                    entry_next = right_i;
                end
            end
            M_CLEAR: begin
                entry_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            match_reg <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            match_reg <= match_next;
        end
    end

endmodule

/* design/split_ordered_handle_list.sv */
// Top level: sequencer, result register and the chain of list cells.
//
//  channel | dir | fields (low bit first)                          | bits
//  s_      | in  | action, handle_in, position                     | 3+HB+log2(DEPTH)
//  m_      | out | status, handle_out, total_count, normal_count   | 3+HB+2*CB
//
// Push, pop, get and clear complete in S_IDLE; a remove compares in every cell
// first, then in S_RESOLVE the hit flag ripples up the chain and the cells shift.
// One transaction is in flight at a time; a new one is taken while the result
// register is empty or being drained. Synchronous active-low reset empties the
// list. A stalled result holds the block at its current transaction.
module split_ordered_handle_list import sohl_pkg::*; #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16,
    localparam int CB    = $clog2(DEPTH + 1),
    localparam int PB    = $clog2(DEPTH),
    localparam int IN_W  = ((3 + HANDLE_BITS + PB + 7) / 8) * 8,
    localparam int OUT_W = ((3 + HANDLE_BITS + 2 * CB + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action, handle_in, position, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, handle_out, total_count, normal_count, pad
);

    // input fields
    action_t                s_action;
    logic [HANDLE_BITS-1:0] s_handle;
    logic [PB-1:0]          s_pos;

    assign s_action = action_t'(s_tdata[2:0]);
    assign s_handle = s_tdata[3 +: HANDLE_BITS];
    assign s_pos    = s_tdata[3 + HANDLE_BITS +: PB];

    // control and result registers
    fsm_t                   state_reg, state_next;
    logic [CB-1:0]          count_reg, count_next;
    logic [CB-1:0]          split_reg, split_next;
    logic                   rem_nrm_reg, rem_nrm_next;
    logic                   m_valid_reg;
    status_t                status_reg;
    logic [HANDLE_BITS-1:0] hout_reg;
    logic [CB-1:0]          tot_reg;
    logic [CB-1:0]          nrm_reg;

    // per-transaction decode
    logic                   out_free;
    logic                   acc;
    logic                   out_load;
    status_t                st;
    logic [HANDLE_BITS-1:0] ho;
    mode_t                  mode;
    logic [CB-1:0]          cpos;
    logic [CB-1:0]          lo;
    logic [CB-1:0]          hi;
    logic [CB-1:0]          rd_sel;
    logic [PB-1:0]          rd_idx;
    logic [HANDLE_BITS-1:0] rd_data;
    logic                   found;

    // cell chain wiring
    logic [HANDLE_BITS-1:0] cell_q [DEPTH];
    logic                   seen [DEPTH + 1];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign acc      = s_tvalid && s_tready;
    assign rd_idx   = rd_sel[PB-1:0];
    assign rd_data  = cell_q[rd_idx];
    assign seen[0]  = 1'b0;
    assign found    = seen[DEPTH];

    // read index: top normal entry, last entry, or the requested position
    always_comb begin
        unique case (s_action)
            A_POP_NORMAL:  rd_sel = split_reg - 1'b1;
            A_POP_OVERLAY: rd_sel = count_reg - 1'b1;
            default:       rd_sel = CB'(s_pos);
        endcase
    end

    // next state, counts and cell command
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        split_next   = split_reg;
        rem_nrm_next = rem_nrm_reg;
        out_load     = 1'b0;
        st           = ST_OK;
        ho           = '0;
        mode         = M_HOLD;
        cpos         = '0;
        lo           = '0;
        hi           = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    out_load = 1'b1;
                    unique case (s_action)
                        A_PUSH_NORMAL, A_PUSH_OVERLAY: begin
                            if (s_handle == '0) begin
                                st = ST_NULL;
                            end else if (count_reg == CB'(DEPTH)) begin
                                st = ST_FULL;
                            end else begin
                                mode       = M_INSERT;
                                count_next = count_reg + 1'b1;
                                if (s_action == A_PUSH_NORMAL) begin
                                    cpos       = split_reg;
                                    split_next = split_reg + 1'b1;
                                end else begin
                                    cpos = count_reg;
                                end
                            end
                        end
                        A_POP_NORMAL: begin
                            if (split_reg == '0) begin
                                st = ST_EMPTY;
                            end else begin
                                cpos       = split_reg - 1'b1;
                                ho         = rd_data;
                                mode       = M_DELETE;
                                count_next = count_reg - 1'b1;
                                split_next = split_reg - 1'b1;
                            end
                        end
                        A_POP_OVERLAY: begin
                            if (count_reg <= split_reg) begin
                                st = ST_EMPTY;
                            end else begin
                                cpos       = count_reg - 1'b1;
                                ho         = rd_data;
                                mode       = M_DELETE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        A_REM_NORMAL, A_REM_OVERLAY: begin
                            if (s_handle == '0) begin
                                st = ST_NULL;
                            end else begin
                                // compare now, result comes from the resolve cycle
                                out_load     = 1'b0;
                                mode         = M_SEARCH;
                                rem_nrm_next = (s_action == A_REM_NORMAL);
                                lo           = (s_action == A_REM_NORMAL) ? '0 : split_reg;
                                hi           = (s_action == A_REM_NORMAL) ? split_reg : count_reg;
                                state_next   = S_RESOLVE;
                            end
                        end
                        A_GET: begin
                            if (CB'(s_pos) >= count_reg) begin
                                st = ST_RANGE;
                            end else begin
                                ho = rd_data;
                            end
                        end
                        A_CLEAR: begin
                            mode       = M_CLEAR;
                            count_next = '0;
                            split_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RESOLVE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (found) begin
                        mode       = M_SHIFT_HIT;
                        count_next = count_reg - 1'b1;
                        if (rem_nrm_reg) begin
                            split_next = split_reg - 1'b1;
                        end
                    end else begin
                        st = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // state and count registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            split_reg   <= '0;
            rem_nrm_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            split_reg   <= split_next;
            rem_nrm_reg <= rem_nrm_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg <= st;
            hout_reg   <= ho;
            tot_reg    <= count_next;
            nrm_reg    <= split_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({nrm_reg, tot_reg, hout_reg, 3'(status_reg)});

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [HANDLE_BITS-1:0] left_v;
        logic [HANDLE_BITS-1:0] right_v;

        if (i == 0) begin : g_lo
            assign left_v = '0;
        end else begin : g_mid_lo
            assign left_v = cell_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_hi
            assign right_v = '0;
        end else begin : g_mid_hi
            assign right_v = cell_q[i+1];
        end

        sohl_cell #(
            .IDX         (i),
            .HANDLE_BITS (HANDLE_BITS),
            .CB          (CB)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .mode_i   (mode),
            .pos_i    (cpos),
            .lo_i     (lo),
            .hi_i     (hi),
            .handle_i ((state_reg == S_IDLE) ? s_handle : '0),
            .left_i   (left_v),
            .right_i  (right_v),
            .seen_i   (seen[i]),
            .seen_o   (seen[i+1]),
            .entry_o  (cell_q[i])
        );
    end

`ifndef SYNTHESIS
    a_split_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        split_reg <= count_reg)
        else $error("split point beyond entry count");

    a_count_le_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CB'(DEPTH))
        else $error("entry count beyond depth");

    a_no_take_resolve: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESOLVE |-> !s_tready)
        else $error("input taken while a remove is resolving");

    a_resolve_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESOLVE) && out_free |=> (state_reg == S_IDLE) && m_valid_reg)
        else $error("remove did not finish with a result");
`endif

endmodule

/* tb/tb_split_ordered_handle_list.sv */
// Testbench for the split ordered handle list: directed, full-list, back-pressure and random tests.
module tb_split_ordered_handle_list;
    import sohl_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 16;
    localparam int IN_W        = 24;
    localparam int OUT_W       = 32;
    localparam int IDLE_LIMIT  = 5000;

    // Expected outcome of one list operation
    typedef struct {
        status_t           status;
        logic [15:0]       handle;
        logic [4:0]        total;
        logic [4:0]        normal;
    } list_result_t;

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;   // action, handle_in, position, zero pad
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // status, handle_out, total_count, normal_count, pad

    // Shadow copy of the list
    logic [15:0]  list_mem [DEPTH];
    int           list_len;
    int           split_at;

    list_result_t pending_results [$];
    list_result_t want;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_left      = 0;
    int           fail_count     = 0;
    int           checked_count  = 0;
    int           sent_count     = 0;
    int           idle_cycles    = 0;
    int           action_seen [8];
    int           status_seen [8];

    split_ordered_handle_list #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20-unit clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Take the cell at index at out of the list and close the gap
    function automatic void drop_entry(int at);
        for (int i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
        list_mem[list_len - 1] = '0;
        list_len--;
    endfunction

    // Apply one operation to the shadow list and return its outcome
    function automatic list_result_t apply_list_op(action_t op, logic [15:0] h, logic [3:0] pos);
        list_result_t r;
        int           lo;
        int           hi;
        int           hit;
        r.status = ST_OK;
        r.handle = '0;
        case (op)
            A_PUSH_NORMAL, A_PUSH_OVERLAY: begin
                if (h == '0) r.status = ST_NULL;
                else if (list_len >= DEPTH) r.status = ST_FULL;
                else if (op == A_PUSH_NORMAL) begin
                    for (int i = list_len; i > split_at; i--) list_mem[i] = list_mem[i - 1];
                    list_mem[split_at] = h;
                    split_at++;
                    list_len++;
                end else begin
                    list_mem[list_len] = h;
                    list_len++;
                end
            end
            A_POP_NORMAL: begin
                if (split_at == 0) r.status = ST_EMPTY;
                else begin
                    r.handle = list_mem[split_at - 1];
                    drop_entry(split_at - 1);
                    split_at--;
                end
            end
            A_POP_OVERLAY: begin
                if (list_len <= split_at) r.status = ST_EMPTY;
                else begin
                    r.handle = list_mem[list_len - 1];
                    drop_entry(list_len - 1);
                end
            end
            A_REM_NORMAL, A_REM_OVERLAY: begin
                lo  = (op == A_REM_NORMAL) ? 0 : split_at;
                hi  = (op == A_REM_NORMAL) ? split_at : list_len;
                hit = -1;
                if (h == '0) r.status = ST_NULL;
                else begin
                    // lowest-index match wins
                    for (int i = lo; i < hi; i++) begin
                        if (hit < 0 && list_mem[i] == h) hit = i;
                    end
                    if (hit < 0) r.status = ST_NOT_FOUND;
                    else begin
                        drop_entry(hit);
                        if (op == A_REM_NORMAL) split_at--;
                    end
                end
            end
            A_GET: begin
                if (int'(pos) >= list_len) r.status = ST_RANGE;
                else r.handle = list_mem[pos];
            end
            default: begin
                foreach (list_mem[i]) list_mem[i] = '0;
                list_len = 0;
                split_at = 0;
            end
        endcase
        r.total  = 5'(list_len);
        r.normal = 5'(split_at);
        return r;
    endfunction

    // Offer one operation, wait for the transaction, record what it should return
    task automatic send_op(action_t op, logic [15:0] h, logic [3:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, h, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_list_op(op, h, pos));
        action_seen[op]++;
        sent_count++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Handle for a push or remove: mostly a region entry or a small pool so matches and duplicates occur
    function automatic logic [15:0] pick_handle(int lo, int hi);
        int r;
        r = $urandom_range(99);
        if (hi > lo && r < 65) return list_mem[$urandom_range(hi - 1, lo)];
        if (r < 85) return 16'($urandom_range(8, 1));
        if (r < 97) return 16'($urandom_range(65535, 1));
        return '0;
    endfunction

    task automatic send_random_op(bit grow);
        int          w;
        action_t     op;
        logic [15:0] h;
        logic [3:0]  pos;
        w = $urandom_range(99);
        if (w < (grow ? 30 : 10)) op = A_PUSH_NORMAL;
        else if (w < (grow ? 60 : 20)) op = A_PUSH_OVERLAY;
        else begin
            op = action_t'(3'($urandom_range(7, 2)));
            if (op == A_CLEAR && $urandom_range(3) != 0) op = A_GET;
        end
        case (op)
            A_REM_NORMAL:  h = pick_handle(0, split_at);
            A_REM_OVERLAY: h = pick_handle(split_at, list_len);
            default:       h = pick_handle(0, 0);
        endcase
        if (op != A_PUSH_NORMAL && op != A_PUSH_OVERLAY && op != A_REM_NORMAL
                && op != A_REM_OVERLAY && $urandom_range(1) == 0)
            h = 16'($urandom_range(65535));
        pos = 4'($urandom_range(15));
        if (list_len > 0 && $urandom_range(2) != 0) pos = 4'($urandom_range(list_len - 1));
        send_op(op, h, pos);
    endtask

    // Empty region, null handle, absent handle, duplicates, range errors
    task automatic test_directed_cases();
        send_op(A_PUSH_NORMAL,  16'h0000, 4'd0);
        send_op(A_PUSH_OVERLAY, 16'h0000, 4'd0);
        send_op(A_POP_NORMAL,   16'h0000, 4'd0);
        send_op(A_POP_OVERLAY,  16'h0000, 4'd0);
        send_op(A_REM_NORMAL,   16'h0005, 4'd0);
        send_op(A_REM_OVERLAY,  16'h0000, 4'd0);
        send_op(A_GET,          16'h0000, 4'd0);
        send_op(A_PUSH_OVERLAY, 16'h8000, 4'd0);
        send_op(A_PUSH_NORMAL,  16'hFFFF, 4'd0);
        send_op(A_PUSH_NORMAL,  16'h0001, 4'd0);
        send_op(A_PUSH_OVERLAY, 16'h0001, 4'd0);
        send_op(A_PUSH_NORMAL,  16'hFFFF, 4'd0);
        send_op(A_GET,          16'h0000, 4'd0);
        send_op(A_GET,          16'hFFFF, 4'd4);
        send_op(A_GET,          16'h0000, 4'd5);
        send_op(A_REM_NORMAL,   16'hFFFF, 4'd0);
        send_op(A_REM_OVERLAY,  16'hFFFF, 4'd0);
        send_op(A_REM_OVERLAY,  16'h0001, 4'd0);
        send_op(A_POP_NORMAL,   16'h0000, 4'd0);
        send_op(A_POP_OVERLAY,  16'h0000, 4'd0);
        send_op(A_POP_OVERLAY,  16'h0000, 4'd0);
        send_op(A_CLEAR,        16'hFFFF, 4'hF);
        send_op(A_GET,          16'h0000, 4'hF);
    endtask

    // Fill to capacity from randomly chosen regions, push into a full list, then read the last cell and pop each region
    task automatic test_full_list();
        send_op(A_CLEAR, 16'h0000, 4'd0);
        repeat (DEPTH) begin
            send_op($urandom_range(1) ? A_PUSH_NORMAL : A_PUSH_OVERLAY,
                    16'($urandom_range(65535, 1)), 4'd0);
        end
        send_op(A_PUSH_NORMAL,  16'h1234, 4'd0);
        send_op(A_PUSH_OVERLAY, 16'h4321, 4'd0);
        send_op(A_GET,          16'h0000, 4'hF);
        send_op(A_POP_NORMAL,   16'h0000, 4'd0);
        send_op(A_POP_OVERLAY,  16'h0000, 4'd0);
    endtask

    // Receiver holds off while the sender keeps offering, then the sender waits for all results
    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (20) send_random_op(1'b1);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic(int n, int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n; i++) send_random_op(((i / 60) % 2) == 0);
    endtask

    // Receiver ready: long hold-off when requested, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                status_seen[want.status]++;
                if (m_tdata[2:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                    fail_count++;
                end
                if (m_tdata[18:3] !== want.handle) begin
                    $error("handle_out: expected %h, got %h", want.handle, m_tdata[18:3]);
                    fail_count++;
                end
                if (m_tdata[23:19] !== want.total) begin
                    $error("total_count: expected %0d, got %0d", want.total, m_tdata[23:19]);
                    fail_count++;
                end
                if (m_tdata[28:24] !== want.normal) begin
                    $error("normal_count: expected %0d, got %0d", want.normal, m_tdata[28:24]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        foreach (list_mem[i]) list_mem[i] = '0;
        list_len = 0;
        split_at = 0;
        foreach (action_seen[i]) action_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_full_list();
        test_back_pressure();
        test_random_traffic(200, 0, 0);
        test_random_traffic(150, 88, 0);
        test_random_traffic(150, 0, 88);
        test_random_traffic(150, 35, 35);
        test_random_traffic(40, 0, 0);

        // drain and let the block settle
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        $display("Ran %0d list operations (push %0d/%0d, pop %0d/%0d, remove %0d/%0d, get %0d, clear %0d)",
                 sent_count, action_seen[A_PUSH_NORMAL], action_seen[A_PUSH_OVERLAY],
                 action_seen[A_POP_NORMAL], action_seen[A_POP_OVERLAY],
                 action_seen[A_REM_NORMAL], action_seen[A_REM_OVERLAY],
                 action_seen[A_GET], action_seen[A_CLEAR]);
        $display("Checked %0d results: ok %0d, full %0d, empty %0d, absent %0d, null %0d, range %0d",
                 checked_count, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
                 status_seen[ST_NULL], status_seen[ST_RANGE]);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
design/sohl_pkg.sv
design/sohl_cell.sv
design/split_ordered_handle_list.sv
tb/tb_split_ordered_handle_list.sv
